// File: hw/rtl/cba_pkg.sv
// Shared constants, codes and widths for the contiguous block allocator.
`timescale 1ns / 1ps

package cba_pkg;

    // Default sizes of the block map and the file table.
    localparam int DEF_NUM_BLOCKS = 128;
    localparam int DEF_NUM_FILES  = 128;

    // Field widths of the request, result and configuration beats.
    localparam int CMD_W     = 1;
    localparam int ID_W      = 7;
    localparam int SIZE_W    = 24;
    localparam int STATUS_W  = 3;
    localparam int BLK_OUT_W = 7;
    localparam int BSIZE_W   = 16;
    localparam int BCOUNT_W  = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    // Block need is the quotient plus one when a remainder is left.
    localparam int NEED_W = SIZE_W + 1;

    // Commands.
    localparam logic [CMD_W-1:0] CMD_ALLOC = 1'b0;
    localparam logic [CMD_W-1:0] CMD_FREE  = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NOSPACE = 3'd1;
    localparam logic [STATUS_W-1:0] ST_USED    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_ABSENT  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_ZERO    = 3'd4;

    // File entry states.
    localparam logic [1:0] FS_UNUSED  = 2'd0;
    localparam logic [1:0] FS_PRESENT = 2'd1;
    localparam logic [1:0] FS_REMOVED = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT = 2'd1;

    // Configuration reset values.
    localparam logic [BSIZE_W-1:0]  RST_BLOCK_SIZE  = 16'd1;
    localparam logic [BCOUNT_W-1:0] RST_BLOCK_COUNT = 8'd128;

endpackage

// File: hw/rtl/cba_div.sv
// Iterative restoring divider that turns a byte size into a block count.
`timescale 1ns / 1ps

module cba_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [cba_pkg::SIZE_W-1:0]   dividend,
    input  logic [cba_pkg::BSIZE_W-1:0]  divisor,
    output logic                         done,
    output logic [cba_pkg::SIZE_W-1:0]   quotient,
    output logic                         rem_nz
);
    import cba_pkg::*;

    localparam int CW = $clog2(SIZE_W);

    logic                run_reg;
    logic                done_reg;
    logic [CW-1:0]       cnt_reg;
    logic [SIZE_W-1:0]   dq_reg;
    logic [BSIZE_W-1:0]  rem_reg;

    logic [BSIZE_W:0]    shifted;
    logic [BSIZE_W:0]    dvs_ext;
    logic [BSIZE_W:0]    diff;
    logic                ge;
    logic [BSIZE_W-1:0]  rem_next;

    // One quotient bit per cycle: shift in the next dividend bit and try a subtract.
    always_comb
    begin
        shifted  = {rem_reg, dq_reg[SIZE_W-1]};
        dvs_ext  = {1'b0, divisor};
        diff     = shifted - dvs_ext;
        ge       = (shifted >= dvs_ext);
        rem_next = ge ? diff[BSIZE_W-1:0] : shifted[BSIZE_W-1:0];
    end

    // Step sequencing; the done pulse follows the last step.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(SIZE_W - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dq_reg  <= dividend;
            rem_reg <= '0;
        end
        else if (run_reg)
        begin
            dq_reg  <= {dq_reg[SIZE_W-2:0], ge};
            rem_reg <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = dq_reg;
    assign rem_nz   = |rem_reg;

endmodule

// File: hw/rtl/contiguous_block_allocator.sv
// Top level of the contiguous disk-block allocator with its sequencer and tables.
`timescale 1ns / 1ps
// Sequence: an entry or zero-size error is reported after the file table lookup, a too-large need
// after the 24-step divider; a free marks its run free in the block map, one block per cycle. An
// allocate runs the divider, then marks its run one block per cycle, and once the bump pointer
// reached the end it first walks the block map first-fit. busy stays high until the result strobe,
// so one request is in flight at a time and the receiver never stalls it. After reset the tables
// are cleared first, with busy high.

module contiguous_block_allocator #(
    parameter int NUM_BLOCKS = cba_pkg::DEF_NUM_BLOCKS,
    parameter int NUM_FILES  = cba_pkg::DEF_NUM_FILES
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [cba_pkg::CMD_W-1:0]        command,
    input  logic [cba_pkg::ID_W-1:0]         file_id,
    input  logic [cba_pkg::SIZE_W-1:0]       file_size,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [cba_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [cba_pkg::CFG_DAT_W-1:0]    cfg_data,
    output logic                             done,
    output logic [cba_pkg::STATUS_W-1:0]     status,
    output logic [cba_pkg::ID_W-1:0]         file_id_res,
    output logic [cba_pkg::BLK_OUT_W-1:0]    first_block,
    output logic [cba_pkg::BLK_OUT_W-1:0]    last_block
);
    import cba_pkg::*;

    localparam int BW    = $clog2(NUM_BLOCKS);
    localparam int NBW   = $clog2(NUM_BLOCKS + 1);
    localparam int FIW   = $clog2(NUM_FILES);
    localparam int CLR_N = (NUM_BLOCKS > NUM_FILES) ? NUM_BLOCKS : NUM_FILES;
    localparam int CLW   = $clog2(CLR_N);

    // Sequencer states.
    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_LOOK   = 4'd2;
    localparam logic [3:0] S_CHECK  = 4'd3;
    localparam logic [3:0] S_DIV    = 4'd4;
    localparam logic [3:0] S_DECIDE = 4'd5;
    localparam logic [3:0] S_SCAN   = 4'd6;
    localparam logic [3:0] S_MARK   = 4'd7;
    localparam logic [3:0] S_FIN    = 4'd8;

    // Control and request registers.
    logic [3:0]           state_reg,  state_next;
    logic [CLW-1:0]       clr_reg,    clr_next;
    logic [CMD_W-1:0]     cmd_reg;
    logic [ID_W-1:0]      id_reg;
    logic [SIZE_W-1:0]    size_reg;
    logic [NEED_W-1:0]    need_reg,   need_next;
    logic [NBW-1:0]       nfb_reg,    nfb_next;
    logic [NBW-1:0]       cnt_reg,    cnt_next;
    logic [NBW-1:0]       len_reg,    len_next;
    logic [NBW-1:0]       start_reg,  start_next;
    logic [BW-1:0]        first_reg,  first_next;
    logic [BW-1:0]        last_reg,   last_next;
    logic [BSIZE_W-1:0]   bsize_reg;
    logic [BCOUNT_W-1:0]  bcount_reg;

    // Result registers.
    logic                  done_reg;
    logic [STATUS_W-1:0]   status_reg;
    logic [ID_W-1:0]       res_id_reg;
    logic [BLK_OUT_W-1:0]  res_first_reg;
    logic [BLK_OUT_W-1:0]  res_last_reg;

    // Memories and their ports.
    logic                 bu_mem [NUM_BLOCKS];
    logic                 bu_rd_reg;
    logic                 bu_we;
    logic [BW-1:0]        bu_waddr;
    logic                 bu_wdata;
    logic [BW-1:0]        bu_raddr;

    logic [1:0]           fs_mem [NUM_FILES];
    logic [BW-1:0]        ff_mem [NUM_FILES];
    logic [BW-1:0]        fl_mem [NUM_FILES];
    logic [1:0]           fs_rd_reg;
    logic [BW-1:0]        ff_rd_reg;
    logic [BW-1:0]        fl_rd_reg;
    logic                 fs_we;
    logic [FIW-1:0]       fs_waddr;
    logic [1:0]           fs_wdata;
    logic                 fl_we;

    // Sequencer helpers.
    logic                 accept;
    logic                 is_alloc;
    logic [FIW-1:0]       fidx;
    logic                 in_range;
    logic [NBW-1:0]       n_val;
    logic [NBW-1:0]       need_nb;
    logic [NBW-1:0]       len1;
    logic                 res_fire;
    logic [STATUS_W-1:0]  res_code;
    logic                 div_start;
    logic                 div_done;
    logic [SIZE_W-1:0]    div_quot;
    logic                 div_rem_nz;
    logic [BSIZE_W-1:0]   bs_eff;

    assign accept    = start && !busy;
    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign is_alloc  = (cmd_reg == CMD_ALLOC);
    assign fidx      = FIW'(id_reg);
    assign in_range  = (32'(id_reg) < 32'(NUM_FILES));
    assign bs_eff    = (bsize_reg == '0) ? BSIZE_W'(1) : bsize_reg;
    assign n_val     = (32'(bcount_reg) > 32'(NUM_BLOCKS)) ? NBW'(NUM_BLOCKS)
                                                           : NBW'(bcount_reg);
    assign need_nb   = NBW'(need_reg);
    assign len1      = len_reg + 1'b1;

    // Divider for the block need.
    cba_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (size_reg),
        .divisor  (bs_eff),
        .done     (div_done),
        .quotient (div_quot),
        .rem_nz   (div_rem_nz)
    );

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bsize_reg  <= RST_BLOCK_SIZE;
            bcount_reg <= RST_BLOCK_COUNT;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == REG_BLOCK_SIZE)
            begin
                bsize_reg <= cfg_data;
            end
            else if (cfg_index == REG_BLOCK_COUNT)
            begin
                bcount_reg <= cfg_data[BCOUNT_W-1:0];
            end
        end
    end

    // Sequencer next-state and memory control.
    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        need_next  = need_reg;
        nfb_next   = nfb_reg;
        cnt_next   = cnt_reg;
        len_next   = len_reg;
        start_next = start_reg;
        first_next = first_reg;
        last_next  = last_reg;
        bu_we      = 1'b0;
        bu_waddr   = cnt_reg[BW-1:0];
        bu_wdata   = is_alloc;
        bu_raddr   = BW'(cnt_reg + 1'b1);
        fs_we      = 1'b0;
        fs_waddr   = fidx;
        fs_wdata   = is_alloc ? FS_PRESENT : FS_REMOVED;
        fl_we      = 1'b0;
        div_start  = 1'b0;
        res_fire   = 1'b0;
        res_code   = ST_OK;

        unique case (state_reg)
            S_CLEAR:
            begin
                bu_we    = (32'(clr_reg) < 32'(NUM_BLOCKS));
                bu_waddr = BW'(clr_reg);
                bu_wdata = 1'b0;
                fs_we    = (32'(clr_reg) < 32'(NUM_FILES));
                fs_waddr = FIW'(clr_reg);
                fs_wdata = FS_UNUSED;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == CLW'(CLR_N - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (is_alloc)
                begin
                    if (!in_range || fs_rd_reg != FS_UNUSED)
                    begin
                        res_fire   = 1'b1;
                        res_code   = ST_USED;
                        state_next = S_IDLE;
                    end
                    else if (size_reg == '0)
                    begin
                        res_fire   = 1'b1;
                        res_code   = ST_ZERO;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = S_DIV;
                    end
                end
                else
                begin
                    if (!in_range || fs_rd_reg != FS_PRESENT)
                    begin
                        res_fire   = 1'b1;
                        res_code   = ST_ABSENT;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        first_next = ff_rd_reg;
                        last_next  = fl_rd_reg;
                        cnt_next   = NBW'(ff_rd_reg);
                        state_next = S_MARK;
                    end
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    need_next  = NEED_W'(div_quot) + NEED_W'(div_rem_nz);
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                bu_raddr = '0;
                if (32'(need_reg) > 32'(n_val))
                begin
                    res_fire   = 1'b1;
                    res_code   = ST_NOSPACE;
                    state_next = S_IDLE;
                end
                else if (nfb_reg < n_val)
                begin
                    // Bump allocation from the pointer on, no fallback.
                    if (32'(need_reg) + 32'(nfb_reg) > 32'(n_val))
                    begin
                        res_fire   = 1'b1;
                        res_code   = ST_NOSPACE;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        first_next = nfb_reg[BW-1:0];
                        last_next  = BW'(nfb_reg + need_nb - 1'b1);
                        nfb_next   = nfb_reg + need_nb;
                        cnt_next   = nfb_reg;
                        state_next = S_MARK;
                    end
                end
                else
                begin
                    cnt_next   = '0;
                    len_next   = '0;
                    start_next = '0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                // bu_rd_reg holds the bit of block cnt_reg; the next one is read meanwhile.
                if (bu_rd_reg)
                begin
                    len_next   = '0;
                    start_next = cnt_reg + 1'b1;
                    cnt_next   = cnt_reg + 1'b1;
                    if (cnt_reg + 1'b1 == n_val)
                    begin
                        res_fire   = 1'b1;
                        res_code   = ST_NOSPACE;
                        state_next = S_IDLE;
                    end
                end
                else if (len1 == need_nb)
                begin
                    first_next = start_reg[BW-1:0];
                    last_next  = cnt_reg[BW-1:0];
                    cnt_next   = start_reg;
                    state_next = S_MARK;
                end
                else
                begin
                    len_next = len1;
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg + 1'b1 == n_val)
                    begin
                        res_fire   = 1'b1;
                        res_code   = ST_NOSPACE;
                        state_next = S_IDLE;
                    end
                end
            end
            S_MARK:
            begin
                bu_we    = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg[BW-1:0] == last_reg)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                fs_we      = 1'b1;
                fl_we      = is_alloc;
                res_fire   = 1'b1;
                res_code   = ST_OK;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            nfb_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            nfb_reg   <= nfb_next;
            done_reg  <= res_fire;
        end
    end

    // Request capture and working registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg  <= command;
            id_reg   <= file_id;
            size_reg <= file_size;
        end
        need_reg  <= need_next;
        cnt_reg   <= cnt_next;
        len_reg   <= len_next;
        start_reg <= start_next;
        first_reg <= first_next;
        last_reg  <= last_next;
    end

    // Result beat; block numbers read as zero on any error.
    always_ff @(posedge clk)
    begin
        if (res_fire)
        begin
            status_reg    <= res_code;
            res_id_reg    <= id_reg;
            res_first_reg <= (res_code == ST_OK) ? BLK_OUT_W'(first_reg) : '0;
            res_last_reg  <= (res_code == ST_OK) ? BLK_OUT_W'(last_reg) : '0;
        end
    end

    // Block map: one bit per block, one write and one read per cycle.
    always_ff @(posedge clk)
    begin
        if (bu_we)
        begin
            bu_mem[bu_waddr] <= bu_wdata;
        end
        bu_rd_reg <= bu_mem[bu_raddr];
    end

    // File table: state, first and last block per entry.
    always_ff @(posedge clk)
    begin
        if (fs_we)
        begin
            fs_mem[fs_waddr] <= fs_wdata;
        end
        fs_rd_reg <= fs_mem[fidx];
    end

    always_ff @(posedge clk)
    begin
        if (fl_we)
        begin
            ff_mem[fidx] <= first_reg;
            fl_mem[fidx] <= last_reg;
        end
        ff_rd_reg <= ff_mem[fidx];
        fl_rd_reg <= fl_mem[fidx];
    end

    assign done        = done_reg;
    assign status      = status_reg;
    assign file_id_res = res_id_reg;
    assign first_block = res_first_reg;
    assign last_block  = res_last_reg;

    // An accepted request always starts with the table lookup.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == S_LOOK)
        else $error("accepted request did not enter lookup");

    // The divider only finishes while the sequencer waits for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == S_DIV)
        else $error("divider finished outside the divide state");

    // Marking never runs past the end of the run.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_MARK |-> cnt_reg[BW-1:0] <= last_reg)
        else $error("block marking overran the run");

    // A successful result always describes an ordered run.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && status_reg == ST_OK) |-> first_reg <= last_reg)
        else $error("ok result with first block after last block");

endmodule
